// ===== rtl/core/piezo_hit_peak_velocity_macros.svh =====
// assertion macros for the piezo hit peak detector
// no dependencies; included by the modules that carry assertions
`ifndef PIEZO_HIT_PEAK_VELOCITY_MACROS_SVH
`define PIEZO_HIT_PEAK_VELOCITY_MACROS_SVH

// property checked on every clock edge outside reset
`define PHD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define PHD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/phd_pkg.sv =====
// shared types and constants for the piezo hit peak detector
// no dependencies
package phd_pkg;

  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned VEL_W      = 7;
  localparam int unsigned BAND_W     = 2;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [SAMPLE_W-1:0] ARM_LEVEL_RST    = SAMPLE_W'(236);
  localparam logic [SAMPLE_W-1:0] SOFT_LIMIT_RST   = SAMPLE_W'(248);
  localparam logic [SAMPLE_W-1:0] MEDIUM_LIMIT_RST = SAMPLE_W'(255);
  localparam logic [HOLD_W-1:0]   HOLD_TICKS_RST   = HOLD_W'(25500);
  localparam logic [VEL_W-1:0]    SOFT_VEL_RST     = VEL_W'(64);
  localparam logic [VEL_W-1:0]    MEDIUM_VEL_RST   = VEL_W'(110);
  localparam logic [VEL_W-1:0]    HARD_VEL_RST     = VEL_W'(127);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ARM_LEVEL    = 3'd0,
    REG_SOFT_LIMIT   = 3'd1,
    REG_MEDIUM_LIMIT = 3'd2,
    REG_HOLD_TICKS   = 3'd3,
    REG_SOFT_VEL     = 3'd4,
    REG_MEDIUM_VEL   = 3'd5,
    REG_HARD_VEL     = 3'd6
  } cfg_reg_e;

  typedef enum logic [BAND_W-1:0] {
    BAND_SOFT   = 2'd0,
    BAND_MEDIUM = 2'd1,
    BAND_HARD   = 2'd2
  } band_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] arm_level;
    logic [SAMPLE_W-1:0] soft_limit;
    logic [SAMPLE_W-1:0] medium_limit;
    logic [HOLD_W-1:0]   hold_ticks;
    logic [VEL_W-1:0]    soft_vel;
    logic [VEL_W-1:0]    medium_vel;
    logic [VEL_W-1:0]    hard_vel;
  } cfg_t;

  // registered input beat handed to the detector
  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] sample;
  } stage_t;

endpackage

// ===== rtl/core/phd_sample_if.sv =====
// sample channel: valid/ready handshake with one converter reading
// depends on phd_pkg
interface phd_sample_if;
  logic                           valid;
  logic                           ready;
  logic [phd_pkg::SAMPLE_W-1:0]   sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== rtl/core/phd_result_if.sv =====
// result channel: valid/ready handshake with velocity, peak and band
// depends on phd_pkg
interface phd_result_if;
  logic                           valid;
  logic                           ready;
  logic [phd_pkg::VEL_W-1:0]      velocity;
  logic [phd_pkg::SAMPLE_W-1:0]   peak;
  logic [phd_pkg::BAND_W-1:0]     band;

  modport source (output valid, output velocity, output peak, output band, input ready);
  modport sink   (input valid, input velocity, input peak, input band, output ready);
endinterface

// ===== rtl/core/phd_cfg_regs.sv =====
// configuration register bank of the piezo hit peak detector
// depends on phd_pkg
module phd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [phd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [phd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output phd_pkg::cfg_t                  cfg_o
);

  phd_pkg::cfg_t cfg_q;
  phd_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (phd_pkg::cfg_reg_e'(cfg_idx_i))
        phd_pkg::REG_ARM_LEVEL:    cfg_d.arm_level    = cfg_data_i[phd_pkg::SAMPLE_W-1:0];
        phd_pkg::REG_SOFT_LIMIT:   cfg_d.soft_limit   = cfg_data_i[phd_pkg::SAMPLE_W-1:0];
        phd_pkg::REG_MEDIUM_LIMIT: cfg_d.medium_limit = cfg_data_i[phd_pkg::SAMPLE_W-1:0];
        phd_pkg::REG_HOLD_TICKS:   cfg_d.hold_ticks   = cfg_data_i[phd_pkg::HOLD_W-1:0];
        phd_pkg::REG_SOFT_VEL:     cfg_d.soft_vel     = cfg_data_i[phd_pkg::VEL_W-1:0];
        phd_pkg::REG_MEDIUM_VEL:   cfg_d.medium_vel   = cfg_data_i[phd_pkg::VEL_W-1:0];
        phd_pkg::REG_HARD_VEL:     cfg_d.hard_vel     = cfg_data_i[phd_pkg::VEL_W-1:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.arm_level    <= phd_pkg::ARM_LEVEL_RST;
      cfg_q.soft_limit   <= phd_pkg::SOFT_LIMIT_RST;
      cfg_q.medium_limit <= phd_pkg::MEDIUM_LIMIT_RST;
      cfg_q.hold_ticks   <= phd_pkg::HOLD_TICKS_RST;
      cfg_q.soft_vel     <= phd_pkg::SOFT_VEL_RST;
      cfg_q.medium_vel   <= phd_pkg::MEDIUM_VEL_RST;
      cfg_q.hard_vel     <= phd_pkg::HARD_VEL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/phd_in_stage.sv =====
// input register: takes one sample beat and holds it until the detector advances
// depends on phd_pkg and phd_sample_if
module phd_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  phd_sample_if.sink      in_i,
  input  logic            advance_i,
  output phd_pkg::stage_t stage_o
);

  logic                         valid_q;
  logic                         valid_d;
  logic [phd_pkg::SAMPLE_W-1:0] sample_q;
  logic                         accept;

  assign in_i.ready = !valid_q || advance_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= in_i.sample;
    end
  end

  assign stage_o.valid  = valid_q;
  assign stage_o.sample = sample_q;

endmodule

// ===== rtl/core/phd_detect.sv =====
// detector: idle/track/hold phases, band select and result register
// depends on phd_pkg, phd_result_if and piezo_hit_peak_velocity_macros.svh
`include "piezo_hit_peak_velocity_macros.svh"

module phd_detect (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  phd_pkg::cfg_t   cfg_i,
  input  phd_pkg::stage_t stage_i,
  output logic            advance_o,
  phd_result_if.source    out_o
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_TRACK = 2'd1,
    PH_HOLD  = 2'd2
  } phase_e;

  phase_e                       phase_q, phase_d;
  logic [phd_pkg::SAMPLE_W-1:0] peak_q, peak_d;
  logic [phd_pkg::HOLD_W-1:0]   hold_q, hold_d;
  logic [phd_pkg::HOLD_W-1:0]   hold_dec;
  logic                         out_valid_q;
  logic [phd_pkg::VEL_W-1:0]    out_vel_q;
  logic [phd_pkg::SAMPLE_W-1:0] out_peak_q;
  phd_pkg::band_e               out_band_q;
  logic                         step;
  logic                         hit;
  phd_pkg::band_e               band_sel;
  logic [phd_pkg::VEL_W-1:0]    vel_sel;

  assign advance_o = !out_valid_q || out_o.ready;
  assign step      = stage_i.valid && advance_o;
  assign hold_dec  = hold_q - 1'b1;

  always_comb begin
    priority if (peak_q < cfg_i.soft_limit) begin
      band_sel = phd_pkg::BAND_SOFT;
      vel_sel  = cfg_i.soft_vel;
    end else if (peak_q < cfg_i.medium_limit) begin
      band_sel = phd_pkg::BAND_MEDIUM;
      vel_sel  = cfg_i.medium_vel;
    end else begin
      band_sel = phd_pkg::BAND_HARD;
      vel_sel  = cfg_i.hard_vel;
    end
  end

  always_comb begin
    phase_d = phase_q;
    peak_d  = peak_q;
    hold_d  = hold_q;
    hit     = 1'b0;
    if (step) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (stage_i.sample > cfg_i.arm_level) begin
            peak_d  = stage_i.sample;
            phase_d = PH_TRACK;
          end
        end
        PH_TRACK: begin
          if (stage_i.sample > peak_q) begin
            peak_d = stage_i.sample;
          end else begin
            hit     = 1'b1;
            hold_d  = cfg_i.hold_ticks;
            phase_d = PH_HOLD;
          end
        end
        default: begin
          // hold, and the unused code behaves the same
          hold_d = hold_dec;
          if (hold_dec == '0) begin
            phase_d = PH_IDLE;
            peak_d  = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      peak_q      <= '0;
      hold_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      peak_q  <= peak_d;
      hold_q  <= hold_d;
      if (advance_o) begin
        out_valid_q <= hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit) begin
      out_vel_q  <= vel_sel;
      out_peak_q <= peak_q;
      out_band_q <= band_sel;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.velocity = out_vel_q;
  assign out_o.peak     = out_peak_q;
  assign out_o.band     = out_band_q;

  `PHD_ASSERT_NEVER(a_idle_peak_clear, clk_i, rst_ni, (phase_q == PH_IDLE) && (peak_q != '0), "peak not cleared in idle")
  `PHD_ASSERT_NEVER(a_track_peak_nonzero, clk_i, rst_ni, (phase_q == PH_TRACK) && (peak_q == '0), "tracking with zero peak")
  `PHD_ASSERT(a_hit_gives_beat, clk_i, rst_ni, (step && (phase_q == PH_TRACK) && (stage_i.sample <= peak_q)) |=> (out_valid_q && (phase_q == PH_HOLD)), "hit end without result beat")
  `PHD_ASSERT(a_hold_from_track, clk_i, rst_ni, ((phase_q == PH_HOLD) && !$past(phase_q == PH_HOLD)) |-> $past(phase_q == PH_TRACK), "hold entered without a hit")

endmodule

// ===== rtl/core/piezo_hit_peak_velocity.sv =====
// Piezo drum trigger peak detector. Takes one 8-bit sample beat per clock and
// returns at most one result beat (velocity, peak, band) per hit. Throughput is
// one sample per cycle while no result waits; a sample passes an input register
// and the phase logic, and the result of the sample that ends a hit is registered
// in the output register. While a result waits the phase logic stalls: the input
// register takes one more sample, then ready stays low until the result beat is
// taken. Configuration writes take effect on the next clock edge.
// depends on phd_pkg, phd_sample_if, phd_result_if, phd_cfg_regs, phd_in_stage,
// phd_detect
module piezo_hit_peak_velocity (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  phd_sample_if.sink                     in_i,
  phd_result_if.source                   out_o,
  input  logic                           cfg_we_i,
  input  logic [phd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [phd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  phd_pkg::cfg_t   cfg;
  phd_pkg::stage_t stage;
  logic            advance;

  phd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  phd_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  phd_detect u_detect (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .stage_i   (stage),
    .advance_o (advance),
    .out_o     (out_o)
  );

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for piezo_hit_peak_velocity: directed and random sample beats
// checked against a cycle-free model of the idle/track/hold detector, under random idling
// depends on phd_pkg, phd_sample_if, phd_result_if and the detector rtl
module tb_top;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_TRACK = 2'd1,
    PH_HOLD  = 2'd2
  } phase_e;

  typedef struct {
    logic [phd_pkg::VEL_W-1:0]    velocity;
    logic [phd_pkg::SAMPLE_W-1:0] peak;
    phd_pkg::band_e               band;
  } hit_t;

  // index past the last register, writes are dropped
  localparam logic [phd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned RX_HOLD_CYCLES = 400;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [phd_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [phd_pkg::CFG_DATA_W-1:0] cfg_data_i;

  phd_sample_if smp_if ();
  phd_result_if res_if ();

  piezo_hit_peak_velocity u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (smp_if),
    .out_o     (res_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  logic [phd_pkg::SAMPLE_W-1:0] sample_q[$];
  hit_t                         hit_q[$];
  logic                         offer_pending = 1'b0;
  int                           errors = 0;
  int unsigned                  tx_idle_pct = 17;
  int unsigned                  rx_idle_pct = 65;
  logic                         rx_hold_req = 1'b0;
  int unsigned                  rx_hold_left = 0;

  phd_pkg::cfg_t                m_cfg;
  phase_e                       m_phase = PH_IDLE;
  logic [phd_pkg::SAMPLE_W-1:0] m_peak = '0;
  logic [phd_pkg::HOLD_W-1:0]   m_hold = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void track_sample(input logic [phd_pkg::SAMPLE_W-1:0] s);
    hit_t h;
    case (m_phase)
      PH_IDLE: begin
        if (s > m_cfg.arm_level) begin
          m_peak  = s;
          m_phase = PH_TRACK;
        end
      end
      PH_TRACK: begin
        if (s > m_peak) begin
          m_peak = s;
        end else begin
          h.peak = m_peak;
          if (m_peak < m_cfg.soft_limit) begin
            h.band     = phd_pkg::BAND_SOFT;
            h.velocity = m_cfg.soft_vel;
          end else if (m_peak < m_cfg.medium_limit) begin
            h.band     = phd_pkg::BAND_MEDIUM;
            h.velocity = m_cfg.medium_vel;
          end else begin
            h.band     = phd_pkg::BAND_HARD;
            h.velocity = m_cfg.hard_vel;
          end
          hit_q.push_back(h);
          m_hold  = m_cfg.hold_ticks;
          m_phase = PH_HOLD;
        end
      end
      default: begin
        m_hold = m_hold - 1'b1;
        if (m_hold == '0) begin
          m_phase = PH_IDLE;
          m_peak  = '0;
        end
      end
    endcase
  endfunction

  // sample driver
  always @(negedge clk_i) begin
    if (!offer_pending) begin
      if (rst_ni && sample_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        smp_if.sample <= sample_q[0];
        smp_if.valid  <= 1'b1;
        offer_pending = 1'b1;
      end else begin
        smp_if.valid <= 1'b0;
      end
    end
  end

  // result ready driver
  always @(negedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_left = RX_HOLD_CYCLES;
      rx_hold_req  = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // monitor: predict on sample beats, check result beats
  always @(posedge clk_i) begin
    hit_t want;
    if (rst_ni) begin
      if (smp_if.valid && smp_if.ready) begin
        void'(sample_q.pop_front());
        offer_pending = 1'b0;
        track_sample(smp_if.sample);
      end
      if (res_if.valid && res_if.ready) begin
        if (hit_q.size() == 0) begin
          $error("result beat with no hit pending: peak %0d", res_if.peak);
          errors++;
        end else begin
          want = hit_q.pop_front();
          if (res_if.velocity !== want.velocity) begin
            $error("velocity mismatch: expected %0d, actual %0d", want.velocity,
                   res_if.velocity);
            errors++;
          end
          if (res_if.peak !== want.peak) begin
            $error("peak mismatch: expected %0d, actual %0d", want.peak, res_if.peak);
            errors++;
          end
          if (res_if.band !== want.band) begin
            $error("band mismatch: expected %0d, actual %0d", want.band, res_if.band);
            errors++;
          end
        end
      end
    end
  end

  task automatic feed(input logic [phd_pkg::SAMPLE_W-1:0] s, input int n = 1);
    repeat (n) sample_q.push_back(s);
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || offer_pending || hit_q.size() != 0) @(posedge clk_i);
  endtask

  // drain, then let the pipeline finish beats that make no result
  task automatic settle();
    drain();
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [phd_pkg::CFG_IDX_W-1:0] idx,
                         input logic [phd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      phd_pkg::REG_ARM_LEVEL:    m_cfg.arm_level    = data[phd_pkg::SAMPLE_W-1:0];
      phd_pkg::REG_SOFT_LIMIT:   m_cfg.soft_limit   = data[phd_pkg::SAMPLE_W-1:0];
      phd_pkg::REG_MEDIUM_LIMIT: m_cfg.medium_limit = data[phd_pkg::SAMPLE_W-1:0];
      phd_pkg::REG_HOLD_TICKS:   m_cfg.hold_ticks   = data[phd_pkg::HOLD_W-1:0];
      phd_pkg::REG_SOFT_VEL:     m_cfg.soft_vel     = data[phd_pkg::VEL_W-1:0];
      phd_pkg::REG_MEDIUM_VEL:   m_cfg.medium_vel   = data[phd_pkg::VEL_W-1:0];
      phd_pkg::REG_HARD_VEL:     m_cfg.hard_vel     = data[phd_pkg::VEL_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [phd_pkg::SAMPLE_W-1:0] pick_level();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [phd_pkg::VEL_W-1:0] pick_vel();
    case ($urandom_range(5))
      0: return 7'd0;
      1: return 7'd127;
      default: return 7'($urandom_range(127));
    endcase
  endfunction

  // mostly whole hits with random content, some noise and wrong hold lengths
  task automatic push_hits(input int n);
    int counted;
    int k;
    int fill;
    logic [phd_pkg::SAMPLE_W-1:0] v;
    logic [phd_pkg::SAMPLE_W-1:0] cand;
    counted = 0;
    while (counted < n) begin
      if (m_cfg.arm_level < 8'd255 && $urandom_range(99) < 80) begin
        k = $urandom_range(3);
        repeat (k) feed(8'($urandom_range(m_cfg.arm_level, 0)));
        v = 8'($urandom_range(255, m_cfg.arm_level + 1));
        if ($urandom_range(3) == 0) begin
          case ($urandom_range(3))
            0: cand = m_cfg.soft_limit;
            1: cand = m_cfg.medium_limit;
            2: cand = m_cfg.soft_limit - 1'b1;
            default: cand = m_cfg.medium_limit - 1'b1;
          endcase
          if (cand > m_cfg.arm_level) v = cand;
        end
        feed(v);
        counted += k + 1;
        k = $urandom_range(3);
        repeat (k) begin
          if (v < 8'd255) begin
            v = 8'($urandom_range(255, v + 1));
            feed(v);
            counted++;
          end
        end
        feed(8'($urandom_range(v, 0)));
        counted++;
        fill = m_cfg.hold_ticks;
        if ($urandom_range(4) == 0) fill = $urandom_range(fill + 2);
        repeat (fill) feed(8'($urandom));
        counted += fill;
      end else begin
        feed(8'($urandom));
        counted++;
      end
    end
  endtask

  initial begin
    logic [phd_pkg::SAMPLE_W-1:0] arm;
    logic [phd_pkg::SAMPLE_W-1:0] soft_lvl;
    logic [phd_pkg::SAMPLE_W-1:0] med_lvl;
    logic [phd_pkg::HOLD_W-1:0]   hold;

    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    smp_if.valid  = 1'b0;
    smp_if.sample = '0;
    res_if.ready  = 1'b0;
    m_cfg = '{arm_level: phd_pkg::ARM_LEVEL_RST, soft_limit: phd_pkg::SOFT_LIMIT_RST,
              medium_limit: phd_pkg::MEDIUM_LIMIT_RST, hold_ticks: phd_pkg::HOLD_TICKS_RST,
              soft_vel: phd_pkg::SOFT_VEL_RST, medium_vel: phd_pkg::MEDIUM_VEL_RST,
              hard_vel: phd_pkg::HARD_VEL_RST};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // reset levels and velocities: arm level not exceeded, all three bands, short hold
    set_reg(phd_pkg::REG_HOLD_TICKS, 16'd2);
    @(posedge clk_i);
    feed(8'd236); feed(8'd237); feed(8'd250); feed(8'd250);
    feed(8'd255, 2);
    feed(8'd240); feed(8'd100);
    feed(8'd255, 2);
    feed(8'd255); feed(8'd255);
    feed(8'd0, 2);
    settle();

    // masked upper bits, band boundaries, hold of one
    set_reg(phd_pkg::REG_ARM_LEVEL, 16'hFF00);
    set_reg(phd_pkg::REG_SOFT_LIMIT, 16'd100);
    set_reg(phd_pkg::REG_MEDIUM_LIMIT, 16'd200);
    set_reg(phd_pkg::REG_HOLD_TICKS, 16'd1);
    set_reg(phd_pkg::REG_SOFT_VEL, 16'hFF80);
    set_reg(phd_pkg::REG_MEDIUM_VEL, 16'd64);
    set_reg(phd_pkg::REG_HARD_VEL, 16'h007F);
    @(posedge clk_i);
    feed(8'd0); feed(8'd1); feed(8'd0); feed(8'd255);
    feed(8'd255); feed(8'd255); feed(8'd255);
    feed(8'd150); feed(8'd100); feed(8'd255);
    feed(8'd100); feed(8'd100); feed(8'd255);
    feed(8'd200); feed(8'd199); feed(8'd255);
    feed(8'd99); feed(8'd99); feed(8'd255);
    settle();

    // limits out of order, dropped index, writes in the middle of a hit
    set_reg(REG_UNUSED, 16'hFFFF);
    set_reg(phd_pkg::REG_ARM_LEVEL, 16'd10);
    set_reg(phd_pkg::REG_SOFT_LIMIT, 16'd200);
    set_reg(phd_pkg::REG_MEDIUM_LIMIT, 16'd100);
    set_reg(phd_pkg::REG_HOLD_TICKS, 16'd2);
    @(posedge clk_i);
    feed(8'd150); feed(8'd0); feed(8'd255, 2);
    feed(8'd220); feed(8'd220); feed(8'd255, 2);
    feed(8'd10); feed(8'd11);
    settle();
    set_reg(phd_pkg::REG_HOLD_TICKS, 16'd3);
    set_reg(phd_pkg::REG_SOFT_VEL, 16'd33);
    set_reg(phd_pkg::REG_MEDIUM_LIMIT, 16'd255);
    @(posedge clk_i);
    feed(8'd12); feed(8'd12); feed(8'd255, 3);
    feed(8'd50); feed(8'd0);
    settle();

    // arm level at top: nothing can start a hit
    set_reg(phd_pkg::REG_ARM_LEVEL, 16'd255);
    @(posedge clk_i);
    feed(8'd255); feed(8'd255); feed(8'd0);
    settle();

    for (int p = 0; p < 12; p++) begin
      if (p == 4) begin
        tx_idle_pct = 65;
        rx_idle_pct = 17;
      end else if (p == 8) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case ($urandom_range(5))
        0: arm = 8'd0;
        1: arm = 8'd254;
        default: arm = 8'($urandom_range(200));
      endcase
      soft_lvl = pick_level();
      med_lvl  = pick_level();
      if ($urandom_range(5) == 0) med_lvl = soft_lvl;
      hold = ($urandom_range(2) == 0) ? 16'd1 : 16'($urandom_range(8, 1));
      set_reg(phd_pkg::REG_ARM_LEVEL, {8'($urandom), arm});
      set_reg(phd_pkg::REG_SOFT_LIMIT, {8'($urandom), soft_lvl});
      set_reg(phd_pkg::REG_MEDIUM_LIMIT, {8'($urandom), med_lvl});
      set_reg(phd_pkg::REG_HOLD_TICKS, hold);
      set_reg(phd_pkg::REG_SOFT_VEL, {9'($urandom), pick_vel()});
      set_reg(phd_pkg::REG_MEDIUM_VEL, {9'($urandom), pick_vel()});
      set_reg(phd_pkg::REG_HARD_VEL, {9'($urandom), pick_vel()});
      @(posedge clk_i);
      push_hits(42);
      if (p == 1 || p == 9) rx_hold_req = 1'b1;
      // sender pauses until all hits are out
      drain();
      push_hits(42);
      settle();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
